FILE: rtl/hfa_pkg.sv
// Shared types and constants of the hole fit allocator.
package hfa_pkg;

    // Field widths fixed by the stream format
    localparam int unsigned SIZE_W     = 16;
    localparam int unsigned HOLE_IDX_W = 4;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned POLICY_W   = 2;
    localparam int unsigned TDATA_W    = 24;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 5;

    // Operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Placement policies; the unused code falls back to first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FIT_POLICY = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLE_COUNT = 1'd1;

    // Sequencer commands to the fit unit
    typedef struct packed {
        logic clear;
        logic step;
    } fit_ctrl_t;

endpackage

FILE: rtl/hfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hfa_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/hfa_fit_unit.sv
// Shared compare/select unit: tracks the chosen hole over a scan and the size left.
module hfa_fit_unit #(
    parameter int unsigned AW = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  hfa_pkg::fit_ctrl_t                   ctrl,
    input  logic [hfa_pkg::POLICY_W-1:0]         policy,
    input  logic [hfa_pkg::SIZE_W-1:0]           req_size,
    input  logic [hfa_pkg::SIZE_W-1:0]           cand_size,
    input  logic [AW-1:0]                        cand_idx,
    output logic                                 found,
    output logic [AW-1:0]                        pick,
    output logic [hfa_pkg::SIZE_W-1:0]           left
);
    logic                        found_reg, found_next;
    logic [AW-1:0]               pick_reg, pick_next;
    logic [hfa_pkg::SIZE_W-1:0]  best_reg, best_next;
    logic                        fits;
    logic                        take;

    // One candidate per step: does it fit, and does it beat the current pick
    always_comb begin
        fits = (cand_size >= req_size);
        take = fits && (!found_reg
               || ((policy == hfa_pkg::POL_BEST)  && (cand_size < best_reg))
               || ((policy == hfa_pkg::POL_WORST) && (cand_size > best_reg)));
        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (ctrl.clear) begin
            found_next = 1'b0;
        end else if (ctrl.step && take) begin
            found_next = 1'b1;
            pick_next  = cand_idx;
            best_next  = cand_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        pick_reg <= pick_next;
        best_reg <= best_next;
    end

    assign found = found_reg;
    assign pick  = pick_reg;
    assign left  = best_reg - req_size;

endmodule

FILE: rtl/hole_fit_allocator_core.sv
// Top level of the hole fit allocator: stream ports, sequencer, hole table.
//
// Keeps a table of HOLES free-hole sizes (reset to zero) and places requests by
// first, best or worst fit. A load goes from transfer straight to the result. A
// request reads min(hole_count, HOLES) table entries, one per cycle through the
// single read port, drains the read pipeline into the shared compare unit, then
// writes back the shrunk hole and presents the result once the output register
// is free; with hole_count 0 it goes straight to the result. The block accepts one
// item at a time; a finished result waits in the output register while the
// next item is taken. Every item gives exactly one result transfer.
module hole_fit_allocator_core #(
    parameter int unsigned HOLES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [hfa_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [hfa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [hfa_pkg::TDATA_W-1:0]         s_tdata,  // op, hole_index[3:0], size[15:0]
    // Results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hfa_pkg::TDATA_W-1:0]         m_tdata   // granted, chosen_hole[3:0], size_left[15:0]
);
    localparam int unsigned AW  = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int unsigned IXW = (AW > hfa_pkg::HOLE_IDX_W) ? AW : hfa_pkg::HOLE_IDX_W;
    localparam int unsigned LW  = ((AW + 1) > hfa_pkg::COUNT_W) ? (AW + 1) : hfa_pkg::COUNT_W;
    localparam logic [LW-1:0] HOLES_L = LW'(HOLES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_SPARE  = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;

    logic [hfa_pkg::POLICY_W-1:0]   policy_reg;
    logic [hfa_pkg::COUNT_W-1:0]    count_reg;

    logic                           op_reg;
    logic                           load_ok_reg;
    logic [AW-1:0]                  addr_reg;
    logic [hfa_pkg::SIZE_W-1:0]     size_reg;
    logic [LW-1:0]                  cnt_reg, cnt_next;

    logic                           dv_reg;
    logic [AW-1:0]                  didx_reg;
    logic                           vq_reg;
    logic [HOLES-1:0]               valid_reg;

    logic                           m_tvalid_reg;
    logic [hfa_pkg::TDATA_W-1:0]    m_tdata_reg;

    // Input field unpacking
    logic                           in_op;
    logic [hfa_pkg::HOLE_IDX_W-1:0] in_idx;
    logic [hfa_pkg::SIZE_W-1:0]     in_size;
    logic [IXW-1:0]                 in_idx_ext;
    logic [LW-1:0]                  count_ext;
    logic [LW-1:0]                  limit;
    logic                           s_xfer;

    assign in_op      = s_tdata[0];
    assign in_idx     = s_tdata[4:1];
    assign in_size    = s_tdata[20:5];
    assign in_idx_ext = IXW'(in_idx);
    assign count_ext  = LW'(count_reg);
    assign limit      = (count_ext > HOLES_L) ? HOLES_L : count_ext;
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= hfa_pkg::POL_FIRST;
            count_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                hfa_pkg::REG_FIT_POLICY: policy_reg <= cfg_wdata[hfa_pkg::POLICY_W-1:0];
                hfa_pkg::REG_HOLE_COUNT: count_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hole table and its read pipeline
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [hfa_pkg::SIZE_W-1:0]     ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [hfa_pkg::SIZE_W-1:0]     ram_rdata;
    logic [hfa_pkg::SIZE_W-1:0]     cand_size;

    assign ram_raddr = cnt_reg[AW-1:0];

    hfa_ram #(
        .WIDTH (hfa_pkg::SIZE_W),
        .DEPTH (HOLES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entries never written read as zero
    assign cand_size = vq_reg ? ram_rdata : '0;

    // Shared compare unit
    hfa_pkg::fit_ctrl_t             fit_ctrl;
    logic                           fit_found;
    logic [AW-1:0]                  fit_pick;
    logic [hfa_pkg::SIZE_W-1:0]     fit_left;

    assign fit_ctrl.clear = s_xfer;
    assign fit_ctrl.step  = dv_reg;

    hfa_fit_unit #(
        .AW (AW)
    ) u_fit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (fit_ctrl),
        .policy    (policy_reg),
        .req_size  (size_reg),
        .cand_size (cand_size),
        .cand_idx  (didx_reg),
        .found     (fit_found),
        .pick      (fit_pick),
        .left      (fit_left)
    );

    // Result of the finishing item
    logic                           fin_go;
    logic                           res_granted;
    logic [AW-1:0]                  res_addr;
    logic [hfa_pkg::SIZE_W-1:0]     res_size;
    logic [IXW-1:0]                 res_hole_ext;
    logic [hfa_pkg::TDATA_W-1:0]    res_word;

    always_comb begin
        if (op_reg == hfa_pkg::OP_LOAD) begin
            res_granted = load_ok_reg;
            res_addr    = addr_reg;
            res_size    = size_reg;
        end else begin
            res_granted = fit_found;
            res_addr    = fit_pick;
            res_size    = fit_left;
        end
    end

    assign fin_go       = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign ram_we       = fin_go && res_granted;
    assign ram_waddr    = res_addr;
    assign ram_wdata    = res_size;
    assign res_hole_ext = IXW'(res_addr);

    // Packed result word; refused items carry all zeros
    always_comb begin
        res_word = '0;
        if (res_granted) begin
            res_word[0]    = 1'b1;
            res_word[4:1]  = res_hole_ext[hfa_pkg::HOLE_IDX_W-1:0];
            res_word[20:5] = res_size;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_xfer) begin
                    if (in_op == hfa_pkg::OP_LOAD || limit == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_next == limit) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_FINISH;
            ST_FINISH: begin
                if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dv_reg    <= 1'b0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            dv_reg    <= (state_reg == ST_SCAN);
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
        cnt_reg  <= cnt_next;
        didx_reg <= ram_raddr;
        vq_reg   <= valid_reg[ram_raddr];
    end

    // Item capture on input transfer
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg      <= in_op;
            size_reg    <= in_size;
            load_ok_reg <= ({1'b0, in_idx_ext} < (IXW + 1)'(HOLES));
            addr_reg    <= in_idx_ext[AW-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fin_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (fin_go) begin
            m_tdata_reg <= res_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_onehot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg < limit))
        else $error("scan address beyond hole count");

    a_write_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_FINISH) && !(m_tvalid_reg && !m_tready))
        else $error("table written outside result hand-off");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[20:1] == '0))
        else $error("refused result carries nonzero fields");

endmodule
